### design/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// Shared types, register codes and CRC helper functions for the parametric
// byte-stream CRC.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrc_pkg;

  // Widest CRC supported, and the byte count limit that follows from it
  localparam int CRC_W     = 32;
  localparam int CRC_BYTES = (CRC_W / 8 > 4) ? 4 : ((CRC_W / 8 < 1) ? 1 : CRC_W / 8);

  localparam int NB_W      = 3;   // width_bytes register
  localparam int CFG_IDX_W = 3;   // register index
  localparam int CFG_W     = 32;  // widest register

  typedef logic [CRC_W-1:0] crc_t;
  typedef logic [NB_W-1:0]  nbytes_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_BYTES    = 3'd0,
    REG_POLYNOMIAL     = 3'd1,
    REG_INIT_VALUE     = 3'd2,
    REG_INIT_IS_DIRECT = 3'd3,
    REG_REFLECT_IN     = 3'd4,
    REG_REFLECT_OUT    = 3'd5,
    REG_FINAL_XOR      = 3'd6
  } cfg_reg_t;

  // Configuration bundle shared by the init and datapath units
  typedef struct packed {
    nbytes_t width_bytes;
    crc_t    polynomial;
    crc_t    init_value;
    logic    init_is_direct;
    logic    reflect_in;
    logic    reflect_out;
    crc_t    final_xor;
  } crc_cfg_t;

  // Clamp the width register to 1..CRC_BYTES
  function automatic nbytes_t eff_bytes(nbytes_t wb);
    nbytes_t r;
    if (wb == '0) begin
      r = nbytes_t'(1);
    end else if (32'(wb) > CRC_BYTES) begin
      r = nbytes_t'(CRC_BYTES);
    end else begin
      r = wb;
    end
    return r;
  endfunction

  // Ones over the low 8*nb bits
  function automatic crc_t order_mask(nbytes_t nb);
    crc_t m;
    m = '0;
    for (int i = 0; i < CRC_BYTES; i++) begin
      if (i < int'(nb)) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

  // Bit-reverse the low 8*nb bits
  function automatic crc_t mirror(crc_t v, nbytes_t nb);
    crc_t r;
    r = '0;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r >> (CRC_W - 8 * int'(nb));
  endfunction

  // One byte of MSB-first update, eight shift/XOR steps
  function automatic crc_t step_normal(crc_t rem, logic [7:0] din, crc_t poly, nbytes_t nb);
    crc_t mask;
    crc_t p;
    crc_t r;
    logic hi;
    int   ord;
    ord  = 8 * int'(nb);
    mask = order_mask(nb);
    p    = poly & mask;
    r    = (rem & mask) ^ (crc_t'(din) << (ord - 8));
    for (int i = 0; i < 8; i++) begin
      hi = r[ord-1];
      r  = (r << 1) & mask;
      if (hi) r = r ^ p;
    end
    return r;
  endfunction

  // One byte of LSB-first update; rpoly is already mirrored and masked
  function automatic crc_t step_reflect(crc_t rem, logic [7:0] din, crc_t rpoly);
    crc_t r;
    r = rem ^ crc_t'(din);
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ rpoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/parametric_crc_byte_stream.sv
// ----------------------------------------------------------------------------
// parametric_crc_byte_stream
// Configurable 8/16/24/32-bit CRC over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries message bytes (tdata) with tlast on the final byte of each
//   message. m_* carries one finished CRC per message, zero above the width.
//   cfg_we/cfg_index/cfg_data write the seven registers; indexes beyond the
//   list are ignored. Write only between messages or with the stream idle.
// Timing:
//   An item is registered on entry and the byte update runs from the input
//   register; a last byte loads its CRC into the output register, which
//   drives m_tvalid. One byte per cycle is sustained while each last byte
//   finds the output register free; the eight-step XOR update is
//   combinational and feeds the remainder register. After reset and after
//   each register write, s_tready stays low while the start value is
//   prepared; a nondirect value takes one byte of zeros per cycle.
// Stall:
//   A waiting result holds m_tdata; non-last bytes keep flowing, and a last
//   byte waits in the input register until the output register frees up.
// Reset: synchronous, clears all control state and reloads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module parametric_crc_byte_stream (
  input  wire                            clk,
  input  wire                            rst,
  // input stream
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [7:0]                     s_tdata,   // [7:0] data_byte
  input  wire                            s_tlast,   // last_byte
  // result stream
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [pcrc_pkg::CRC_W-1:0]     m_tdata,   // [31:0] crc_value
  // configuration
  input  wire                            cfg_we,
  input  wire  [pcrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [pcrc_pkg::CFG_W-1:0]     cfg_data
);
  import pcrc_pkg::*;

  crc_cfg_t   cfg;
  crc_t       prep_init;
  logic       busy;
  logic       advance;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_bytes    <= nbytes_t'(4);
      cfg.polynomial     <= 32'h04C1_1DB7;
      cfg.init_value     <= 32'hFFFF_FFFF;
      cfg.init_is_direct <= 1'b1;
      cfg.reflect_in     <= 1'b1;
      cfg.reflect_out    <= 1'b1;
      cfg.final_xor      <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_BYTES:    cfg.width_bytes    <= cfg_data[NB_W-1:0];
        REG_POLYNOMIAL:     cfg.polynomial     <= cfg_data[CRC_W-1:0];
        REG_INIT_VALUE:     cfg.init_value     <= cfg_data[CRC_W-1:0];
        REG_INIT_IS_DIRECT: cfg.init_is_direct <= cfg_data[0];
        REG_REFLECT_IN:     cfg.reflect_in     <= cfg_data[0];
        REG_REFLECT_OUT:    cfg.reflect_out    <= cfg_data[0];
        REG_FINAL_XOR:      cfg.final_xor      <= cfg_data[CRC_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign s_tready = !rst && !busy && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  pcrc_init u_init (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_we),
    .cfg       (cfg),
    .prep_init (prep_init),
    .busy      (busy)
  );

  pcrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .prep_init (prep_init),
    .in_valid  (s1_valid),
    .in_byte   (s1_byte),
    .in_last   (s1_last),
    .advance   (advance),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

### design/pcrc_init.sv
// ----------------------------------------------------------------------------
// pcrc_init
// Prepares the start value of the remainder after reset and after every
// register write: nondirect values are advanced one byte of zeros per cycle,
// then the value is reflected when input reflection is on.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_init (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_wr,
  input  pcrc_pkg::crc_cfg_t cfg,
  output pcrc_pkg::crc_t    prep_init,
  output logic              busy
);
  import pcrc_pkg::*;

  logic    reload;
  logic    run;
  nbytes_t cnt;
  crc_t    v;
  nbytes_t nb;
  crc_t    mask;

  assign nb   = eff_bytes(cfg.width_bytes);
  assign mask = order_mask(nb);
  assign busy = reload | run;

  // Control: restart on reset or on any write
  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= 1'b1;
      run    <= 1'b0;
      cnt    <= '0;
    end else begin
      reload <= cfg_wr;
      if (reload) begin
        run <= 1'b1;
        cnt <= cfg.init_is_direct ? nbytes_t'(0) : nb;
      end else if (run) begin
        if (cnt != '0) begin
          cnt <= cnt - nbytes_t'(1);
        end else begin
          run <= 1'b0;
        end
      end
    end
  end

  // Value: nondirect conversion is a zero byte per step, order/8 steps
  always_ff @(posedge clk) begin
    if (reload) begin
      v <= cfg.init_value & mask;
    end else if (run) begin
      if (cnt != '0) begin
        v <= step_normal(v, 8'h00, cfg.polynomial, nb);
      end else begin
        prep_init <= cfg.reflect_in ? mirror(v, nb) : v;
      end
    end
  end

endmodule

`default_nettype wire

### design/pcrc_core.sv
// ----------------------------------------------------------------------------
// pcrc_core
// Byte update of the running remainder and the result register. One byte
// per cycle; a last byte waits for a free output slot, then loads its CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_core (
  input  wire                clk,
  input  wire                rst,
  input  pcrc_pkg::crc_cfg_t cfg,
  input  pcrc_pkg::crc_t     prep_init,
  input  wire                in_valid,
  input  wire  [7:0]         in_byte,
  input  wire                in_last,
  output logic               advance,
  output logic               m_tvalid,
  input  wire                m_tready,
  output pcrc_pkg::crc_t     m_tdata
);
  import pcrc_pkg::*;

  logic    msg_open;
  crc_t    rem;
  nbytes_t nb;
  crc_t    mask;
  crc_t    rpoly;
  crc_t    rem_in;
  crc_t    rem_next;
  crc_t    crc_fin;
  logic    out_free;

  // Byte update
  assign nb       = eff_bytes(cfg.width_bytes);
  assign mask     = order_mask(nb);
  assign rpoly    = mirror(cfg.polynomial & mask, nb);
  assign rem_in   = (msg_open ? rem : prep_init) & mask;
  assign rem_next = cfg.reflect_in ? step_reflect(rem_in, in_byte, rpoly)
                                   : step_normal(rem_in, in_byte, cfg.polynomial, nb);

  // Finish: optional reflection, final XOR, mask to width
  always_comb begin
    crc_fin = rem_next;
    if (cfg.reflect_out != cfg.reflect_in) crc_fin = mirror(rem_next, nb);
    crc_fin = (crc_fin ^ cfg.final_xor) & mask;
  end

  // Non-last bytes never need the output slot
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || out_free);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_open <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (advance) begin
        msg_open <= !in_last;
        if (in_last) m_tvalid <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance) begin
      rem <= rem_next;
      if (in_last) m_tdata <= crc_fin;
    end
  end

endmodule

`default_nettype wire

### design/pcrc_checker.sv
// ----------------------------------------------------------------------------
// pcrc_checker
// Port-level checks for the parametric CRC block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            s_tvalid,
  input wire                            s_tready,
  input wire                            s_tlast,
  input wire                            m_tvalid,
  input wire                            m_tready,
  input wire  [pcrc_pkg::CRC_W-1:0]     m_tdata,
  input wire                            cfg_we
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Start value is being prepared right after reset
  a_rst_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready right after reset");

  // A register write always triggers start value preparation
  a_cfg_busy: assert property (@(posedge clk)
    cfg_we |=> !s_tready)
    else $error("input ready right after register write");

  // No result can leave the cycle after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A non-last byte followed by no further byte gives no result on an idle output
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast ##1 !(s_tvalid && s_tready) && !m_tvalid
      |=> !m_tvalid)
    else $error("result without a last byte");

endmodule

bind parametric_crc_byte_stream pcrc_checker u_pcrc_checker (.*);

`default_nettype wire

### tb/sv/parametric_crc_byte_stream_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parametric_crc_byte_stream_test
// Drives message bytes through the CRC block under a series of register
// settings (standard CRC-32, width extremes, nondirect start values, mixed
// reflection, writes while a message is open) and checks every finished CRC
// against a CRC computed bit by bit alongside the stream.
// ----------------------------------------------------------------------------

module parametric_crc_byte_stream_test;
  import pcrc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // past the register list
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned NUM_PHASES  = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // [7:0] data_byte
  logic                 s_tlast = 1'b0; // last_byte
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [CRC_W-1:0]     m_tdata;        // [31:0] crc_value
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Bytes waiting to go out, CRCs waiting to come back
  byte_item_t  byte_q[$];
  crc_t        crc_expected_q[$];
  byte_item_t  on_bus;

  // Shadow copy of the registers and of the running CRC
  crc_cfg_t    crc_setup;
  crc_t        crc_remainder;
  logic        msg_open;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;
  crc_t        want;

  parametric_crc_byte_stream i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // CRC arithmetic, one bit at a time
  // --------------------------------------------------------------------------
  function automatic int unsigned crc_bits(nbytes_t wb);
    if (wb == '0) return 8;
    if (int'(wb) > CRC_BYTES) return 8 * CRC_BYTES;
    return 8 * int'(wb);
  endfunction

  function automatic crc_t ones_below(int unsigned n);
    crc_t m;
    m = '0;
    for (int i = 0; i < n; i++) m[i] = 1'b1;
    return m;
  endfunction

  function automatic crc_t flip_bits(crc_t v, int unsigned n);
    crc_t r;
    r = '0;
    for (int i = 0; i < n; i++) r[n-1-i] = v[i];
    return r;
  endfunction

  // Start value of a message under the current registers
  function automatic crc_t seed_value();
    int unsigned n;
    crc_t msk;
    crc_t p;
    crc_t v;
    logic hi;
    n   = crc_bits(crc_setup.width_bytes);
    msk = ones_below(n);
    p   = crc_setup.polynomial & msk;
    v   = crc_setup.init_value & msk;
    // nondirect form: run order zero bits through the register
    if (!crc_setup.init_is_direct) begin
      for (int i = 0; i < n; i++) begin
        hi = v[n-1];
        v  = (v << 1) & msk;
        if (hi) v = v ^ p;
      end
    end
    if (crc_setup.reflect_in) v = flip_bits(v, n);
    return v;
  endfunction

  function automatic crc_t absorb_byte(crc_t rem, logic [7:0] b);
    int unsigned n;
    crc_t msk;
    crc_t p;
    crc_t rp;
    logic hi;
    n   = crc_bits(crc_setup.width_bytes);
    msk = ones_below(n);
    p   = crc_setup.polynomial & msk;
    rem = rem & msk;
    if (crc_setup.reflect_in) begin
      rp  = flip_bits(p, n);
      rem = rem ^ crc_t'(b);
      for (int i = 0; i < 8; i++) rem = rem[0] ? ((rem >> 1) ^ rp) : (rem >> 1);
    end else begin
      rem = rem ^ (crc_t'(b) << (n - 8));
      for (int i = 0; i < 8; i++) begin
        hi  = rem[n-1];
        rem = (rem << 1) & msk;
        if (hi) rem = rem ^ p;
      end
    end
    return rem & msk;
  endfunction

  // Fold one accepted byte in; a last byte yields the finished CRC
  task automatic crc_track_byte(byte_item_t it);
    int unsigned n;
    crc_t c;
    if (!msg_open) crc_remainder = seed_value();
    crc_remainder = absorb_byte(crc_remainder, it.data);
    if (!it.last) begin
      msg_open = 1'b1;
    end else begin
      n = crc_bits(crc_setup.width_bytes);
      c = crc_remainder;
      if (crc_setup.reflect_out != crc_setup.reflect_in) c = flip_bits(c, n);
      crc_expected_q.push_back((c ^ crc_setup.final_xor) & ones_below(n));
      msg_open = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: holds an item until taken, may idle between items
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) crc_track_byte(on_bus);
      if (!s_tvalid || s_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= on_bus.data;
          s_tlast  <= on_bus.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random gaps, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (crc_expected_q.size() == 0) begin
        $error("unexpected result: crc_value %h", m_tdata);
        err_cnt++;
      end else begin
        want = crc_expected_q.pop_front();
        if (m_tdata !== want) begin
          $error("crc_value: expected %h, actual %h", want, m_tdata);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers (the main sequence calls them at the falling edge)
  // --------------------------------------------------------------------------
  task automatic push_byte(logic [7:0] d, logic l);
    byte_item_t it;
    it.data = d;
    it.last = l;
    byte_q.push_back(it);
  endtask

  task automatic push_message(int unsigned len, logic closed);
    for (int i = 0; i < len; i++) push_byte(8'($urandom), closed && (i == len - 1));
  endtask

  // Wait until every byte is taken and every CRC is back, then let the
  // pipeline empty
  task automatic drain_stream();
    while (byte_q.size() != 0 || s_tvalid || crc_expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, crc_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_WIDTH_BYTES:    crc_setup.width_bytes    = val[NB_W-1:0];
      REG_POLYNOMIAL:     crc_setup.polynomial     = val;
      REG_INIT_VALUE:     crc_setup.init_value     = val;
      REG_INIT_IS_DIRECT: crc_setup.init_is_direct = val[0];
      REG_REFLECT_IN:     crc_setup.reflect_in     = val[0];
      REG_REFLECT_OUT:    crc_setup.reflect_out    = val[0];
      REG_FINAL_XOR:      crc_setup.final_xor      = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned total;
    int unsigned len;
    crc_t        wb;

    // register defaults after reset: reflected CRC-32
    crc_setup.width_bytes    = nbytes_t'(4);
    crc_setup.polynomial     = 32'h04C11DB7;
    crc_setup.init_value     = '1;
    crc_setup.init_is_direct = 1'b1;
    crc_setup.reflect_in     = 1'b1;
    crc_setup.reflect_out    = 1'b1;
    crc_setup.final_xor      = '1;
    crc_remainder            = '0;
    msg_open                 = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: check string, single-byte messages of all zeros and all ones
    send_idle_pct = 26;
    recv_idle_pct = 78;
    for (int i = 1; i <= 9; i++) push_byte(8'h30 + 8'(i), i == 9);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    drain_stream();

    // registers change while a message is open; its remainder carries over
    write_reg(REG_REFLECT_OUT, 32'h0);
    write_reg(REG_FINAL_XOR, 32'h0F0F0F0F);
    push_byte(8'hFF, 1'b1);
    drain_stream();

    // write past the register list is ignored; width 0 acts as one byte
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_WIDTH_BYTES, 32'h0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b1);
    drain_stream();

    // width above the limit acts as four bytes
    write_reg(REG_WIDTH_BYTES, 32'h7);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    drain_stream();

    // nondirect start value, MSB first, 16 bits
    write_reg(REG_WIDTH_BYTES, 32'h2);
    write_reg(REG_INIT_IS_DIRECT, 32'h0);
    write_reg(REG_REFLECT_IN, 32'h0);
    write_reg(REG_INIT_VALUE, 32'h1234_FFFF);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);
    drain_stream();

    // Random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 26;
        recv_idle_pct = 78;
      end else if (p < 8) begin
        send_idle_pct = 78;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (p == 0) begin
        // all minimums
        write_reg(REG_WIDTH_BYTES, 32'h1);
        write_reg(REG_POLYNOMIAL, 32'h0);
        write_reg(REG_INIT_VALUE, 32'h0);
        write_reg(REG_INIT_IS_DIRECT, 32'h0);
        write_reg(REG_REFLECT_IN, 32'h0);
        write_reg(REG_REFLECT_OUT, 32'h0);
        write_reg(REG_FINAL_XOR, 32'h0);
      end else if (p == 1) begin
        // all maximums
        write_reg(REG_WIDTH_BYTES, 32'h4);
        write_reg(REG_POLYNOMIAL, '1);
        write_reg(REG_INIT_VALUE, '1);
        write_reg(REG_INIT_IS_DIRECT, 32'h1);
        write_reg(REG_REFLECT_IN, 32'h1);
        write_reg(REG_REFLECT_OUT, 32'h1);
        write_reg(REG_FINAL_XOR, '1);
      end else begin
        // mostly legal widths, sometimes the clamped ones; junk in upper bits
        wb = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
        write_reg(REG_WIDTH_BYTES, ($urandom & ~crc_t'(7)) | wb);
        write_reg(REG_POLYNOMIAL, $urandom);
        write_reg(REG_INIT_VALUE, $urandom);
        write_reg(REG_INIT_IS_DIRECT, $urandom);
        write_reg(REG_REFLECT_IN, $urandom);
        write_reg(REG_REFLECT_OUT, $urandom);
        write_reg(REG_FINAL_XOR, $urandom);
      end
      if (p % 4 == 3) write_reg(REG_UNUSED, $urandom);

      total = 0;
      while (total < 55) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        push_message(len, 1'b1);
        total += len;
      end

      // long receiver hold-off while bytes keep coming
      if (p == 2 || p == 6) hold_left = 120;

      // sometimes leave a message open across the next register change
      if (p != NUM_PHASES - 1 && $urandom_range(2) == 0)
        push_message($urandom_range(1, 3), 1'b0);

      drain_stream();
    end

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
